@@ src/spq_pkg.sv @@
// Shared constants and types for the sorted priority queue.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int PRIO_W      = 8;
    localparam int STATUS_W    = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [DATA_W-1:0] FAIL_DATA = '1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } entry_t;

endpackage

`default_nettype wire

@@ src/spq_if.sv @@
// Valid/ready channel interfaces for the queue's request and result beats.
// Depends on spq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [spq_pkg::DATA_W-1:0]      item_data;
    logic [spq_pkg::PRIO_W-1:0]      prio;

    modport source (output valid, output operation, output item_data, output prio,
                    input ready);
    modport sink   (input valid, input operation, input item_data, input prio,
                    output ready);
endinterface

interface spq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [spq_pkg::DATA_W-1:0]      result_data;
    logic [spq_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output result_data, output status, input ready);
    modport sink   (input valid, input result_data, input status, output ready);
endinterface

`default_nettype wire

@@ src/sorted_priority_queue_top.sv @@
// Sorted priority queue: entry RAM plus a sequencer that scans and shifts it.
// Depends on spq_pkg and the channel interfaces in spq_if.sv.
//
// Usage:
//   req (sink): operation 0 inserts {item_data, prio}; operation 1 pops by the
//   prio rule (0 rear, negative rear if its prio <= -prio, positive rearmost
//   exact match). rsp (source): one beat per request, result_data and status.
//   Entries live in a single-port-write RAM with a registered read; one
//   shared compare unit walks it one entry per cycle.
// Sequence, request beat to result valid:
//   insert full or into empty queue, pop on empty queue: straight to FINISH
//   insert: scan from the rear, moving entries back, then write the item
//   pop: scan for a match, then move the entries behind it forward
// Throughput: one request at a time; req.ready is high only when the
//   sequencer is idle, so the next beat is taken only once the result
//   is registered.
// Reset: the count clears; RAM contents stay unknown; only slots below the
//   count are used.
// Stall: the result register holds until rsp.ready; a new request is taken
//   meanwhile, and its result waits in the sequencer until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    localparam int IDX_W    = spq_pkg::IDX_W;
    localparam int CNT_W    = spq_pkg::CNT_W;
    localparam int DATA_W   = spq_pkg::DATA_W;
    localparam int PRIO_W   = spq_pkg::PRIO_W;
    localparam int STATUS_W = spq_pkg::STATUS_W;

    typedef enum logic [2:0] {
        IDLE,
        INS_SCAN,
        INS_PUT,
        POP_SCAN,
        POP_SHIFT,
        FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    spq_pkg::entry_t        item_reg, item_next;
    logic [DATA_W-1:0]      res_data_reg, res_data_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]      out_data_reg, out_data_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    spq_pkg::entry_t        mem [spq_pkg::QUEUE_DEPTH];
    spq_pkg::entry_t        rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    spq_pkg::entry_t        wr_entry;

    logic                   req_fire;
    logic [IDX_W-1:0]       last_idx;
    logic [CNT_W-1:0]       cnt_dec;
    logic signed [PRIO_W:0] rd_prio_ext;
    logic signed [PRIO_W:0] item_prio_ext;
    logic signed [PRIO_W:0] neg_bound;
    logic                   ins_shift;
    logic                   pop_match;

    assign req_fire = req.valid && req.ready;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign cnt_dec  = count_reg - CNT_W'(1);

    // shared compare unit
    assign rd_prio_ext   = {rd_data_reg.prio[PRIO_W-1], rd_data_reg.prio};
    assign item_prio_ext = {item_reg.prio[PRIO_W-1], item_reg.prio};
    assign neg_bound     = -item_prio_ext;

    // equal priority ahead of a non-front entry, strictly higher to pass the front
    assign ins_shift = (ptr_reg != '0) ? (rd_prio_ext <= item_prio_ext)
                                       : (rd_prio_ext <  item_prio_ext);

    always_comb
    begin
        priority if (item_reg.prio == '0)
            pop_match = 1'b1;
        else if (item_reg.prio[PRIO_W-1])
            pop_match = (rd_prio_ext <= neg_bound);
        else
            pop_match = (rd_data_reg.prio == item_reg.prio);
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        item_next       = item_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        rd_addr         = ptr_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_entry        = rd_data_reg;

        unique case (state_reg)
            IDLE:
            begin
                rd_addr = last_idx;
                if (req_fire)
                begin
                    item_next.data = req.item_data;
                    item_next.prio = req.prio;
                    ptr_next       = last_idx;
                    if (req.operation == spq_pkg::OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(spq_pkg::QUEUE_DEPTH))
                        begin
                            res_data_next   = spq_pkg::FAIL_DATA;
                            res_status_next = spq_pkg::ST_FULL;
                            state_next      = FINISH;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = '0;
                            wr_entry.data   = req.item_data;
                            wr_entry.prio   = req.prio;
                            count_next      = count_reg + CNT_W'(1);
                            res_data_next   = '0;
                            res_status_next = spq_pkg::ST_OK;
                            state_next      = FINISH;
                        end
                        else
                        begin
                            state_next = INS_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_data_next   = spq_pkg::FAIL_DATA;
                            res_status_next = spq_pkg::ST_EMPTY;
                            state_next      = FINISH;
                        end
                        else
                        begin
                            state_next = POP_SCAN;
                        end
                    end
                end
            end

            INS_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg + IDX_W'(1);
                if (ins_shift)
                begin
                    wr_entry = rd_data_reg;
                    if (ptr_reg == '0)
                    begin
                        state_next = INS_PUT;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - IDX_W'(1);
                        rd_addr  = ptr_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    wr_entry        = item_reg;
                    count_next      = count_reg + CNT_W'(1);
                    res_data_next   = '0;
                    res_status_next = spq_pkg::ST_OK;
                    state_next      = FINISH;
                end
            end

            INS_PUT:
            begin
                wr_en           = 1'b1;
                wr_addr         = ptr_reg;
                wr_entry        = item_reg;
                count_next      = count_reg + CNT_W'(1);
                res_data_next   = '0;
                res_status_next = spq_pkg::ST_OK;
                state_next      = FINISH;
            end

            POP_SCAN:
            begin
                if (pop_match)
                begin
                    res_data_next   = rd_data_reg.data;
                    res_status_next = spq_pkg::ST_OK;
                    count_next      = cnt_dec;
                    if (CNT_W'(ptr_reg) == cnt_dec)
                    begin
                        state_next = FINISH;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + IDX_W'(1);
                        rd_addr    = ptr_reg + IDX_W'(1);
                        state_next = POP_SHIFT;
                    end
                end
                else if (!item_reg.prio[PRIO_W-1] && ptr_reg != '0)
                begin
                    ptr_next = ptr_reg - IDX_W'(1);
                    rd_addr  = ptr_reg - IDX_W'(1);
                end
                else
                begin
                    res_data_next   = spq_pkg::FAIL_DATA;
                    res_status_next = spq_pkg::ST_NOMATCH;
                    state_next      = FINISH;
                end
            end

            POP_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg - IDX_W'(1);
                wr_entry = rd_data_reg;
                if (CNT_W'(ptr_reg) == count_reg)
                begin
                    state_next = FINISH;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                    rd_addr  = ptr_reg + IDX_W'(1);
                end
            end

            FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg;
                    out_status_next = res_status_reg;
                    state_next      = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // entry RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        item_reg       <= item_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign req.ready       = (state_reg == IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_data = out_data_reg;
    assign rsp.status      = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(spq_pkg::QUEUE_DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg + CNT_W'(1) == $past(count_reg)))
        else $error("entry count moved by more than one");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == INS_SCAN || state_reg == POP_SCAN) |->
            (CNT_W'(ptr_reg) < count_reg))
        else $error("scan pointer outside stored entries");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == POP_SHIFT) |->
            (ptr_reg != '0 && CNT_W'(ptr_reg) <= count_reg))
        else $error("pop shift pointer outside stored entries");

    a_finish_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FINISH && !out_valid_reg) |=> (out_valid_reg && state_reg == IDLE))
        else $error("result not registered when output was free");

endmodule

`default_nettype wire
